>>> rtl/binned_fir_audio_filter_top_macros.svh
// Assertion helpers used by the filter control module.
`ifndef BINNED_FIR_AUDIO_FILTER_TOP_MACROS_SVH
`define BINNED_FIR_AUDIO_FILTER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define BFA_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bfa: same-cycle check failed");

// Next-cycle implication, disabled while reset is low.
`define BFA_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bfa: next-cycle check failed");

`endif

>>> rtl/bfa_pkg.sv
package bfa_pkg;

    localparam int TAPS       = 16;
    localparam int IDX_W      = (TAPS > 1) ? $clog2(TAPS) : 1;
    localparam int CNT_W      = $clog2(TAPS + 1);

    localparam int TIME_W     = 63;
    localparam int BOUND_W    = 64;
    localparam int SAMP_W     = 24;
    localparam int COEF_W     = 18;
    localparam int CIDX_W     = 4;
    localparam int BIN_W      = 28;
    localparam int PERIOD_W   = 30;
    localparam int TAPCNT_W   = 5;
    localparam int PROD_W     = COEF_W + SAMP_W;
    localparam int ACC_W      = PROD_W + $clog2(TAPS) + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = PERIOD_W;

    localparam int SAMP_MAX   = 8388607;
    localparam int SAMP_MIN   = -8388608;
    localparam int BIN_MAX    = 134217727;
    localparam int BIN_MIN    = -134217728;
    localparam int COEF_HALF  = 32768;
    localparam int ROUND_HALF = 32768;
    localparam int FRAC_SHIFT = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = PERIOD_W'(20833333);
    localparam logic [TAPCNT_W-1:0] TAPCNT_RESET = TAPCNT_W'(2);

    localparam logic [CFG_IDX_W-1:0] REG_PERIOD = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_TAPS   = CFG_IDX_W'(1);

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EVAL = 4'b0010,
        S_MAC  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    typedef struct packed {
        logic load;
        logic eval;
        logic mac_step;
        logic fin;
    } t_dp_cmd;

    typedef struct packed {
        logic close;
        logic mac_last;
    } t_dp_sts;

endpackage

>>> rtl/bfa_in_if.sv
interface bfa_in_if;
    import bfa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     kind;
    logic [TIME_W-1:0]        time_ps;
    logic signed [SAMP_W-1:0] sample;
    logic [CIDX_W-1:0]        coef_index;
    logic signed [COEF_W-1:0] coef_value;

    modport source (output valid, kind, time_ps, sample, coef_index, coef_value,
                    input ready);
    modport sink   (input valid, kind, time_ps, sample, coef_index, coef_value,
                    output ready);
endinterface

>>> rtl/bfa_out_if.sv
interface bfa_out_if;
    import bfa_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [SAMP_W-1:0] out_sample;

    modport source (output valid, out_sample, input ready);
    modport sink   (input valid, out_sample, output ready);
endinterface

>>> rtl/binned_fir_audio_filter_top.sv
// Binned FIR audio filter. Each accepted beat is either an audio sample
// (kind 0) or a coefficient write (kind 1). Samples are summed into a bin;
// when a sample's time reaches the next period boundary (or on the very
// first sample) the bin closes, its sum is saturated to Q1.23 and shifted
// into the delay line, and one filtered Q1.23 output beat is produced from
// the first tap_count taps. A coefficient write loads one tap, flushes the
// delay line and produces no output. A new beat is accepted only once the
// previous one is finished. A closing beat walks all TAPS taps through the
// single shared multiply-accumulate unit, one tap per cycle, and then
// drains the product register. The output register lets the result wait
// for the sink; a new result waits only if the previous one is still
// untaken.
// Configuration: register 0 is period_ps, register 1 is tap_count; write
// them only while the block is idle.
module binned_fir_audio_filter_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    bfa_in_if.sink                         i_in,
    bfa_out_if.source                      o_out,
    input  logic                           i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [bfa_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bfa_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;
    logic    in_ready;
    logic    out_valid;

    // sequencing: accept, evaluate the bin, walk the taps, deliver
    bfa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    // bin accumulator, boundary tracking, delay line and MAC
    bfa_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_kind       (i_in.kind),
        .i_time_ps    (i_in.time_ps),
        .i_sample     (i_in.sample),
        .i_coef_index (i_in.coef_index),
        .i_coef_value (i_in.coef_value),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_out_sample (o_out.out_sample)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

>>> rtl/bfa_datapath.sv
module bfa_datapath (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  bfa_pkg::t_dp_cmd                  i_cmd,
    output bfa_pkg::t_dp_sts                  o_sts,
    input  logic                              i_kind,
    input  logic [bfa_pkg::TIME_W-1:0]        i_time_ps,
    input  logic signed [bfa_pkg::SAMP_W-1:0] i_sample,
    input  logic [bfa_pkg::CIDX_W-1:0]        i_coef_index,
    input  logic signed [bfa_pkg::COEF_W-1:0] i_coef_value,
    input  logic                              i_cfg_we,
    input  logic [bfa_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bfa_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    output logic signed [bfa_pkg::SAMP_W-1:0] o_out_sample
);
    import bfa_pkg::*;

    // latched item
    logic                     r_kind;
    logic [TIME_W-1:0]        r_time;
    logic signed [SAMP_W-1:0] r_sample;
    logic [CIDX_W-1:0]        r_cidx;
    logic signed [COEF_W-1:0] r_cval;

    // configuration and filter state
    logic [PERIOD_W-1:0]      r_period;
    logic [TAPCNT_W-1:0]      r_taps;
    logic signed [COEF_W-1:0] r_coef  [TAPS];
    logic signed [SAMP_W-1:0] r_delay [TAPS];
    logic signed [BIN_W-1:0]  r_bin;
    logic [BOUND_W-1:0]       r_nb;
    logic                     r_armed;

    // multiply-accumulate
    logic signed [PROD_W-1:0] r_prod;
    logic signed [ACC_W-1:0]  r_acc;
    logic [CNT_W-1:0]         r_cnt;
    logic signed [SAMP_W-1:0] r_out;

    logic                     n_close;
    logic [BOUND_W-1:0]       n_base;
    logic [BOUND_W:0]         n_sum;
    logic [BOUND_W-1:0]       n_boundary;
    logic signed [SAMP_W-1:0] n_closed;
    logic signed [BIN_W:0]    n_bin_sum;
    logic signed [BIN_W-1:0]  n_bin;
    logic [CNT_W-1:0]         n_taps_used;
    logic [IDX_W-1:0]         n_idx;
    logic signed [PROD_W-1:0] n_prod;
    logic signed [ACC_W:0]    n_round;
    logic signed [SAMP_W-1:0] n_out;

    always_comb begin
        n_close = (r_kind == KIND_SAMPLE) && (!r_armed || ({1'b0, r_time} >= r_nb));
        n_base  = r_armed ? r_nb : {1'b0, r_time};
        n_sum   = {1'b0, n_base} + (BOUND_W + 1)'(r_period);
        // saturate instead of wrapping past the top of the time range
        n_boundary = n_sum[BOUND_W] ? '1 : n_sum[BOUND_W-1:0];

        if (r_bin > SAMP_MAX) begin
            n_closed = SAMP_W'(SAMP_MAX);
        end else if (r_bin < SAMP_MIN) begin
            n_closed = SAMP_W'(SAMP_MIN);
        end else begin
            n_closed = r_bin[SAMP_W-1:0];
        end

        n_bin_sum = (BIN_W + 1)'(r_bin) + (BIN_W + 1)'(r_sample);
        if (n_bin_sum > BIN_MAX) begin
            n_bin = BIN_W'(BIN_MAX);
        end else if (n_bin_sum < BIN_MIN) begin
            n_bin = BIN_W'(BIN_MIN);
        end else begin
            n_bin = n_bin_sum[BIN_W-1:0];
        end

        n_taps_used = (32'(r_taps) > TAPS) ? CNT_W'(TAPS) : CNT_W'(r_taps);
        n_idx       = r_cnt[IDX_W-1:0];
        // keep both arms signed so the product stays a signed multiply
        n_prod      = (r_cnt < n_taps_used) ? r_coef[n_idx] * r_delay[n_idx] : PROD_W'(0);

        // round to nearest, ties up, then saturate
        n_round = ((ACC_W + 1)'(r_acc) + (ACC_W + 1)'(ROUND_HALF)) >>> FRAC_SHIFT;
        if (n_round > SAMP_MAX) begin
            n_out = SAMP_W'(SAMP_MAX);
        end else if (n_round < SAMP_MIN) begin
            n_out = SAMP_W'(SAMP_MIN);
        end else begin
            n_out = n_round[SAMP_W-1:0];
        end
    end

    // payload capture, MAC and output registers, no reset
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_kind   <= i_kind;
            r_time   <= i_time_ps;
            r_sample <= i_sample;
            r_cidx   <= i_coef_index;
            r_cval   <= i_coef_value;
        end
        if (i_cmd.eval && n_close) begin
            r_prod <= '0;
            r_acc  <= '0;
            r_cnt  <= '0;
        end else if (i_cmd.mac_step) begin
            r_prod <= n_prod;
            r_acc  <= r_acc + ACC_W'(r_prod);
            r_cnt  <= r_cnt + CNT_W'(1);
        end
        if (i_cmd.fin) begin
            r_out <= n_out;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period <= PERIOD_RESET;
            r_taps   <= TAPCNT_RESET;
            r_bin    <= '0;
            r_nb     <= '0;
            r_armed  <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                r_delay[i] <= '0;
                r_coef[i]  <= (i < 2) ? COEF_W'(COEF_HALF) : '0;
            end
        end else begin
            if (i_cfg_we && (i_cfg_idx == REG_PERIOD)) begin
                r_period <= i_cfg_data[PERIOD_W-1:0];
            end
            if (i_cfg_we && (i_cfg_idx == REG_TAPS)) begin
                r_taps <= i_cfg_data[TAPCNT_W-1:0];
            end
            if (i_cmd.eval) begin
                if (r_kind == KIND_COEF) begin
                    // load one tap, flush the delay line
                    if (32'(r_cidx) < TAPS) begin
                        r_coef[r_cidx[IDX_W-1:0]] <= r_cval;
                    end
                    for (int i = 0; i < TAPS; i++) begin
                        r_delay[i] <= '0;
                    end
                end else if (n_close) begin
                    r_nb    <= n_boundary;
                    r_armed <= 1'b1;
                    r_bin   <= {{(BIN_W - SAMP_W){r_sample[SAMP_W-1]}}, r_sample};
                    r_delay[0] <= n_closed;
                    for (int i = 1; i < TAPS; i++) begin
                        r_delay[i] <= r_delay[i-1];
                    end
                end else begin
                    r_bin <= n_bin;
                end
            end
        end
    end

    assign o_sts.close    = n_close;
    assign o_sts.mac_last = (32'(r_cnt) == TAPS);
    assign o_out_sample   = r_out;

endmodule

>>> rtl/bfa_ctrl.sv
module bfa_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output bfa_pkg::t_dp_cmd o_cmd,
    input  bfa_pkg::t_dp_sts i_sts
);
    import bfa_pkg::*;
    `include "binned_fir_audio_filter_top_macros.svh"

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   n_out_valid;
    logic   out_free;
    logic   in_fire;

    assign in_fire  = i_in_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_sts.close ? S_MAC : S_IDLE;
            end
            S_MAC: begin
                if (i_sts.mac_last) begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd.load     = in_fire;
        o_cmd.eval     = (r_state == S_EVAL);
        o_cmd.mac_step = (r_state == S_MAC);
        o_cmd.fin      = (r_state == S_FIN) && out_free;

        n_out_valid = r_out_valid;
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    `BFA_ASSERT_NXT(a_accept_to_eval, i_clk, i_rst_n, in_fire, r_state == S_EVAL)
    `BFA_ASSERT_NXT(a_mac_done_to_fin, i_clk, i_rst_n, (r_state == S_MAC) && i_sts.mac_last, r_state == S_FIN)
    `BFA_ASSERT_NXT(a_fin_sets_valid, i_clk, i_rst_n, o_cmd.fin, r_out_valid)
    `BFA_ASSERT_NXT(a_taken_clears, i_clk, i_rst_n, r_out_valid && i_out_ready && !o_cmd.fin, !r_out_valid)

endmodule
